@@ rtl/sem_pkg.sv @@
// Shared types, sizes and constants of the Sobel edge magnitude block.
package sem_pkg;

    // Frame limits and derived widths
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int WIDTH_W    = $clog2(MAX_WIDTH + 1);
    localparam int HEIGHT_W   = $clog2(MAX_HEIGHT + 1);
    localparam int MIN_SIZE   = 3;

    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    // Pixel and gradient arithmetic
    localparam int PIX_W      = 8;
    localparam int LINE_W     = 3 * PIX_W;
    localparam int SUM_W      = 10;
    localparam int PROD_W     = 20;
    localparam int DIV3_MUL   = 683;
    localparam int DIV3_SHIFT = 11;
    localparam int GRAD_W     = 11;
    localparam int ENERGY_W   = 22;
    localparam int REM_W      = 17;
    localparam int SQRT_STEPS = PIX_W;
    localparam int MAG_MAX    = 255;

    // Front-to-back queue
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCOUNT_W = $clog2(QDEPTH + 1);

    // Register map: register index taken from paddr[2]
    localparam int  APB_ADDR_W = 3;
    localparam int  APB_DATA_W = 32;
    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] alpha;
    } sem_pixel_t;

    typedef struct packed {
        logic [COL_W-1:0] out_col;
        logic [ROW_W-1:0] out_row;
        logic [PIX_W-1:0] magnitude;
        logic [PIX_W-1:0] out_alpha;
        logic             frame_last;
    } sem_result_t;

    // Gradient beat passed from the front to the back
    typedef struct packed {
        logic [COL_W-1:0]         col;
        logic [ROW_W-1:0]         row;
        logic [PIX_W-1:0]         alpha;
        logic                     last;
        logic signed [GRAD_W-1:0] sx;
        logic signed [GRAD_W-1:0] sy;
    } sem_grad_t;

endpackage

@@ rtl/sem_ram.sv @@
// Generic simple dual-port RAM with registered read.
module sem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/sem_front.sv @@
// Front end: accepts pixels, tracks position, line stores, window and Sobel sums.
module sem_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  sem_pkg::sem_pixel_t           pixel,
    input  logic [sem_pkg::WIDTH_W-1:0]   image_width,
    input  logic [sem_pkg::HEIGHT_W-1:0]  image_height,
    input  logic                          restart,
    input  logic [sem_pkg::QCOUNT_W-1:0]  q_count,
    output logic                          grad_valid,
    output sem_pkg::sem_grad_t            grad
);

    localparam int CW = sem_pkg::QCOUNT_W + 1;

    typedef struct packed {
        logic [sem_pkg::COL_W-1:0] addr;
        logic [sem_pkg::PIX_W-1:0] gray;
        logic [sem_pkg::PIX_W-1:0] alpha;
        logic                      emit;
        logic [sem_pkg::COL_W-1:0] col;
        logic [sem_pkg::ROW_W-1:0] row;
        logic                      last;
    } sem_s1_t;

    logic                          accept;
    logic [sem_pkg::COL_W-1:0]     col_reg, col_next;
    logic [sem_pkg::ROW_W-1:0]     row_reg, row_next;
    logic [sem_pkg::WIDTH_W-1:0]   col_inc;
    logic [sem_pkg::HEIGHT_W-1:0]  row_inc;
    logic [sem_pkg::SUM_W-1:0]     rgb_sum;
    logic [sem_pkg::PROD_W-1:0]    rgb_prod;
    logic                          s1_valid_reg;
    sem_s1_t                       s1_reg, s1_next;
    logic [sem_pkg::LINE_W-1:0]    line_rdata;
    logic [sem_pkg::LINE_W-1:0]    line_wdata;
    logic [sem_pkg::PIX_W-1:0]     top, mid, old_alpha;
    logic [sem_pkg::PIX_W-1:0]     win_reg [6];
    logic [sem_pkg::PIX_W-1:0]     center_alpha_reg;
    logic signed [11:0]            l0, l1, l2, m0, m2, r0, r1, r2;
    logic signed [11:0]            sx_full, sy_full;

    // Credit check: room for every beat already in flight
    assign full   = (CW'(q_count) + CW'(s1_valid_reg)) >= CW'(sem_pkg::QDEPTH);
    assign accept = push && !full;

    // Gray level: (r+g+b)/3 by reciprocal multiply
    assign rgb_sum  = sem_pkg::SUM_W'(pixel.red) + sem_pkg::SUM_W'(pixel.green)
                    + sem_pkg::SUM_W'(pixel.blue);
    assign rgb_prod = sem_pkg::PROD_W'(rgb_sum) * sem_pkg::PROD_W'(sem_pkg::DIV3_MUL);

    // Position counters and the beat classification
    assign col_inc = sem_pkg::WIDTH_W'(col_reg) + sem_pkg::WIDTH_W'(1);
    assign row_inc = sem_pkg::HEIGHT_W'(row_reg) + sem_pkg::HEIGHT_W'(1);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_inc >= image_width)
            begin
                col_next = '0;
                row_next = (row_inc >= image_height) ? '0 : sem_pkg::ROW_W'(row_inc);
            end
            else
            begin
                col_next = sem_pkg::COL_W'(col_inc);
            end
        end
        s1_next.addr  = col_reg;
        s1_next.gray  = sem_pkg::PIX_W'(rgb_prod >> sem_pkg::DIV3_SHIFT);
        s1_next.alpha = pixel.alpha;
        s1_next.emit  = (col_reg >= sem_pkg::COL_W'(2)) && (row_reg >= sem_pkg::ROW_W'(2));
        s1_next.col   = col_reg - sem_pkg::COL_W'(1);
        s1_next.row   = row_reg - sem_pkg::ROW_W'(1);
        s1_next.last  = (col_inc == image_width) && (row_inc == image_height);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (restart)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
    end

    // Line store: {upper gray, middle gray, middle alpha} per column
    assign top        = line_rdata[3*sem_pkg::PIX_W-1:2*sem_pkg::PIX_W];
    assign mid        = line_rdata[2*sem_pkg::PIX_W-1:sem_pkg::PIX_W];
    assign old_alpha  = line_rdata[sem_pkg::PIX_W-1:0];
    assign line_wdata = {mid, s1_reg.gray, s1_reg.alpha};

    sem_ram #(
        .WIDTH (sem_pkg::LINE_W),
        .DEPTH (sem_pkg::MAX_WIDTH)
    ) u_line (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_reg.addr),
        .wdata (line_wdata),
        .re    (accept),
        .raddr (col_reg),
        .rdata (line_rdata)
    );

    // 3x3 window shift: two previous columns held, current column from the line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
            center_alpha_reg <= '0;
        end
        else if (s1_valid_reg)
        begin
            win_reg[0]       <= win_reg[3];
            win_reg[1]       <= win_reg[4];
            win_reg[2]       <= win_reg[5];
            win_reg[3]       <= top;
            win_reg[4]       <= mid;
            win_reg[5]       <= s1_reg.gray;
            center_alpha_reg <= old_alpha;
        end
    end

    // Sobel sums
    assign l0 = signed'({4'b0, win_reg[0]});
    assign l1 = signed'({4'b0, win_reg[1]});
    assign l2 = signed'({4'b0, win_reg[2]});
    assign m0 = signed'({4'b0, win_reg[3]});
    assign m2 = signed'({4'b0, win_reg[5]});
    assign r0 = signed'({4'b0, top});
    assign r1 = signed'({4'b0, mid});
    assign r2 = signed'({4'b0, s1_reg.gray});

    assign sx_full = (r0 - l0) + ((r1 - l1) <<< 1) + (r2 - l2);
    assign sy_full = (l0 + (m0 <<< 1) + r0) - (l2 + (m2 <<< 1) + r2);

    assign grad_valid = s1_valid_reg && s1_reg.emit;
    assign grad.col   = s1_reg.col;
    assign grad.row   = s1_reg.row;
    assign grad.alpha = center_alpha_reg;
    assign grad.last  = s1_reg.last;
    assign grad.sx    = sx_full[sem_pkg::GRAD_W-1:0];
    assign grad.sy    = sy_full[sem_pkg::GRAD_W-1:0];

endmodule

@@ rtl/sem_queue.sv @@
// Short queue of gradient beats between front and back.
module sem_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push_valid,
    input  sem_pkg::sem_grad_t           push_data,
    input  logic                         pop_req,
    output logic                         valid,
    output sem_pkg::sem_grad_t           data,
    output logic [sem_pkg::QCOUNT_W-1:0] count
);

    sem_pkg::sem_grad_t             mem_reg [sem_pkg::QDEPTH];
    logic [sem_pkg::QPTR_W-1:0]     wptr_reg, rptr_reg;
    logic [sem_pkg::QCOUNT_W-1:0]   count_reg, count_next;
    logic                           do_pop;

    assign valid  = (count_reg != '0);
    assign do_pop = pop_req && valid;
    assign data   = mem_reg[rptr_reg];
    assign count  = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push_valid && !do_pop)
        begin
            count_next = count_reg + sem_pkg::QCOUNT_W'(1);
        end
        else if (!push_valid && do_pop)
        begin
            count_next = count_reg - sem_pkg::QCOUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push_valid)
            begin
                wptr_reg <= wptr_reg + sem_pkg::QPTR_W'(1);
            end
            if (do_pop)
            begin
                rptr_reg <= rptr_reg + sem_pkg::QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

    // Occupancy never goes past the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= sem_pkg::QCOUNT_W'(sem_pkg::QDEPTH))
        else $error("queue count beyond depth");

    // Front credit must keep pushes off a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> (count_reg != sem_pkg::QCOUNT_W'(sem_pkg::QDEPTH)))
        else $error("push into full queue");

    // Pointers stay consistent with the count
    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wptr_reg == rptr_reg))
        else $error("queue pointers disagree with empty count");

endmodule

@@ rtl/sem_back.sv @@
// Back end: gradient energy and a pipelined bit-per-stage square root.
module sem_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 grad_valid,
    input  sem_pkg::sem_grad_t   grad,
    output logic                 grad_pop,
    input  logic                 pop,
    output logic                 empty,
    output sem_pkg::sem_result_t result
);

    localparam int NSTAGE = sem_pkg::SQRT_STEPS + 1;

    typedef struct packed {
        logic [sem_pkg::COL_W-1:0] col;
        logic [sem_pkg::ROW_W-1:0] row;
        logic [sem_pkg::PIX_W-1:0] alpha;
        logic                      last;
        logic                      sat;
        logic [sem_pkg::REM_W-1:0] rem;
        logic [sem_pkg::PIX_W-1:0] root;
    } sem_sqrt_t;

    // One restoring step for root bit k
    function automatic sem_sqrt_t sqrt_step(input sem_sqrt_t s, input int k);
        sem_sqrt_t          o;
        logic [17:0]        trial;
        o     = s;
        trial = (18'(s.root) << (k + 1)) + (18'(1) << (2 * k));
        if (trial <= 18'(s.rem))
        begin
            o.rem  = sem_pkg::REM_W'(18'(s.rem) - trial);
            o.root = s.root | sem_pkg::PIX_W'(1 << k);
        end
        return o;
    endfunction

    logic                               advance;
    logic                               valid_reg [NSTAGE];
    sem_sqrt_t                          stage_reg [NSTAGE];
    sem_sqrt_t                          stage_next [NSTAGE];
    logic signed [sem_pkg::ENERGY_W-1:0] sx_e, sy_e, sq_x, sq_y;
    logic [sem_pkg::ENERGY_W-1:0]       energy;

    // Whole pipeline moves unless the output beat is held
    assign advance  = !valid_reg[NSTAGE-1] || pop;
    assign grad_pop = advance;

    // Squares and energy feed the first stage
    assign sx_e   = sem_pkg::ENERGY_W'(grad.sx);
    assign sy_e   = sem_pkg::ENERGY_W'(grad.sy);
    assign sq_x   = sx_e * sx_e;
    assign sq_y   = sy_e * sy_e;
    assign energy = sem_pkg::ENERGY_W'(sq_x + sq_y);

    always_comb
    begin
        stage_next[0].col   = grad.col;
        stage_next[0].row   = grad.row;
        stage_next[0].alpha = grad.alpha;
        stage_next[0].last  = grad.last;
        stage_next[0].sat   = |energy[sem_pkg::ENERGY_W-1:16];
        stage_next[0].rem   = sem_pkg::REM_W'(energy[15:0]);
        stage_next[0].root  = '0;
        for (int i = 1; i < NSTAGE; i++)
        begin
            stage_next[i] = sqrt_step(stage_reg[i-1], NSTAGE - 1 - i);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSTAGE; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (advance)
        begin
            valid_reg[0] <= grad_valid;
            for (int i = 1; i < NSTAGE; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < NSTAGE; i++)
            begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    // Last stage is the output register
    assign empty             = !valid_reg[NSTAGE-1];
    assign result.out_col    = stage_reg[NSTAGE-1].col;
    assign result.out_row    = stage_reg[NSTAGE-1].row;
    assign result.out_alpha  = stage_reg[NSTAGE-1].alpha;
    assign result.frame_last = stage_reg[NSTAGE-1].last;
    assign result.magnitude  = stage_reg[NSTAGE-1].sat ?
                               sem_pkg::PIX_W'(sem_pkg::MAG_MAX) : stage_reg[NSTAGE-1].root;

endmodule

@@ rtl/sobel_edge_magnitude_3x3_top.sv @@
// Top level of the 3x3 Sobel edge magnitude block: register port and datapath.
//
// Pixels of one frame enter in raster order on the input queue port: a beat
// is taken when push is high and full is low. Results leave on the output
// queue port: the oldest result shows while empty is low and is taken when
// pop is high. Only interior pixels give a result, so the first two rows,
// and the first two columns of every row, produce none. The result for
// center (c,r) follows the beat of pixel (c+1,r+1).
// Throughput is one pixel per cycle while full is low; the line store is a
// single RAM read at accept and rewritten in the following cycle, and the
// square root runs one root bit per pipeline stage. After the accepting
// edge a beat passes the front register, the queue and the root pipeline.
// When pop stays low the square root pipeline holds, the four-entry queue
// fills, and full rises; no beat is lost.
// Reset sets width 640, height 480 and the frame position to the first
// pixel. The line store is not cleared; no clearing pass is run. Writing
// either register restarts the frame position.
module sobel_edge_magnitude_3x3_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  sem_pkg::sem_pixel_t            pixel,
    output logic                           empty,
    input  logic                           pop,
    output sem_pkg::sem_result_t           result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sem_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [sem_pkg::APB_DATA_W-1:0] pwdata,
    output logic [sem_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    logic [sem_pkg::WIDTH_W-1:0]   width_reg, width_next;
    logic [sem_pkg::HEIGHT_W-1:0]  height_reg, height_next;
    logic [sem_pkg::WIDTH_W-1:0]   wr_width;
    logic [sem_pkg::HEIGHT_W-1:0]  wr_height;
    logic                          cfg_write;
    logic [sem_pkg::QCOUNT_W-1:0]  q_count;
    logic                          front_valid, q_valid, q_pop;
    sem_pkg::sem_grad_t            front_grad, q_grad;

    // Register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign wr_width  = pwdata[sem_pkg::WIDTH_W-1:0];
    assign wr_height = pwdata[sem_pkg::HEIGHT_W-1:0];

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_write)
        begin
            unique case (paddr[2])
                sem_pkg::CFG_IDX_WIDTH:
                begin
                    if (wr_width < sem_pkg::WIDTH_W'(sem_pkg::MIN_SIZE))
                        width_next = sem_pkg::WIDTH_W'(sem_pkg::MIN_SIZE);
                    else if (wr_width > sem_pkg::WIDTH_W'(sem_pkg::MAX_WIDTH))
                        width_next = sem_pkg::WIDTH_W'(sem_pkg::MAX_WIDTH);
                    else
                        width_next = wr_width;
                end
                sem_pkg::CFG_IDX_HEIGHT:
                begin
                    if (wr_height < sem_pkg::HEIGHT_W'(sem_pkg::MIN_SIZE))
                        height_next = sem_pkg::HEIGHT_W'(sem_pkg::MIN_SIZE);
                    else if (wr_height > sem_pkg::HEIGHT_W'(sem_pkg::MAX_HEIGHT))
                        height_next = sem_pkg::HEIGHT_W'(sem_pkg::MAX_HEIGHT);
                    else
                        height_next = wr_height;
                end
                default:
                begin
                    width_next  = width_reg;
                    height_next = height_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= sem_pkg::WIDTH_W'(sem_pkg::RESET_WIDTH);
            height_reg <= sem_pkg::HEIGHT_W'(sem_pkg::RESET_HEIGHT);
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // Readback of the stored values
    assign prdata = (paddr[2] == sem_pkg::CFG_IDX_HEIGHT) ?
                    sem_pkg::APB_DATA_W'(height_reg) : sem_pkg::APB_DATA_W'(width_reg);

    // Datapath
    sem_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .pixel        (pixel),
        .image_width  (width_reg),
        .image_height (height_reg),
        .restart      (cfg_write),
        .q_count      (q_count),
        .grad_valid   (front_valid),
        .grad         (front_grad)
    );

    sem_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_data  (front_grad),
        .pop_req    (q_pop),
        .valid      (q_valid),
        .data       (q_grad),
        .count      (q_count)
    );

    sem_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .grad_valid (q_valid),
        .grad       (q_grad),
        .grad_pop   (q_pop),
        .pop        (pop),
        .empty      (empty),
        .result     (result)
    );

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the 3x3 Sobel edge magnitude block.
`timescale 1ns / 100ps

// Tracks the frame position, line stores and window, and holds the edges due
class edge_scoreboard;
    bit [7:0]          upper_gray [sem_pkg::MAX_WIDTH];
    bit [7:0]          middle_gray [sem_pkg::MAX_WIDTH];
    bit [7:0]          middle_alpha [sem_pkg::MAX_WIDTH];
    bit [7:0]          win [6];
    bit [7:0]          center_alpha;
    int unsigned       col_pos;
    int unsigned       row_pos;
    int unsigned       frame_width;
    int unsigned       frame_height;
    sem_pkg::sem_result_t edges_due [$];
    int unsigned       errors;

    function new();
        frame_width  = sem_pkg::RESET_WIDTH;
        frame_height = sem_pkg::RESET_HEIGHT;
        col_pos      = 0;
        row_pos      = 0;
        center_alpha = '0;
        errors       = 0;
        foreach (win[i]) win[i] = '0;
    endfunction

    function int unsigned pending();
        return edges_due.size();
    endfunction

    // Register write: saturate to the legal range and restart the frame
    function void apply_reg_write(logic idx, logic [31:0] value);
        int unsigned v;
        if (idx == sem_pkg::CFG_IDX_WIDTH) begin
            v = value[11:0];
            frame_width = (v < sem_pkg::MIN_SIZE) ? sem_pkg::MIN_SIZE :
                          (v > sem_pkg::MAX_WIDTH) ? sem_pkg::MAX_WIDTH : v;
        end
        else begin
            v = value[12:0];
            frame_height = (v < sem_pkg::MIN_SIZE) ? sem_pkg::MIN_SIZE :
                           (v > sem_pkg::MAX_HEIGHT) ? sem_pkg::MAX_HEIGHT : v;
        end
        col_pos = 0;
        row_pos = 0;
    endfunction

    // Floor square root of the gradient energy, saturated to 8 bits
    function bit [7:0] clamped_root(int energy);
        int root;
        int trial;
        if (energy >= 65536)
            return 8'(sem_pkg::MAG_MAX);
        root = 0;
        for (int b = 7; b >= 0; b--) begin
            trial = root | (1 << b);
            if (trial * trial <= energy)
                root = trial;
        end
        return root[7:0];
    endfunction

    // One accepted pixel: update line stores and window, queue an edge if interior
    function void predict_edge(sem_pkg::sem_pixel_t px);
        int gray;
        int top;
        int mid;
        int sx;
        int sy;
        bit [7:0] old_alpha;
        sem_pkg::sem_result_t edge_res;
        gray = (int'(px.red) + int'(px.green) + int'(px.blue)) / 3;
        top = upper_gray[col_pos];
        mid = middle_gray[col_pos];
        old_alpha = middle_alpha[col_pos];
        upper_gray[col_pos]   = mid[7:0];
        middle_gray[col_pos]  = gray[7:0];
        middle_alpha[col_pos] = px.alpha;

        if (col_pos >= 2 && row_pos >= 2) begin
            sx = (top - int'(win[0])) + 2 * (mid - int'(win[1])) + (gray - int'(win[2]));
            sy = (int'(win[0]) + 2 * int'(win[3]) + top)
               - (int'(win[2]) + 2 * int'(win[5]) + gray);
            edge_res.out_col    = sem_pkg::COL_W'(col_pos - 1);
            edge_res.out_row    = sem_pkg::ROW_W'(row_pos - 1);
            edge_res.magnitude  = clamped_root(sx * sx + sy * sy);
            edge_res.out_alpha  = center_alpha;
            edge_res.frame_last = (col_pos + 1 == frame_width) &&
                                  (row_pos + 1 == frame_height);
            edges_due.push_back(edge_res);
        end

        // slide the window one column
        win[0] = win[3];
        win[1] = win[4];
        win[2] = win[5];
        win[3] = top[7:0];
        win[4] = mid[7:0];
        win[5] = gray[7:0];
        center_alpha = old_alpha;

        // advance raster position, wrapping at frame end
        col_pos++;
        if (col_pos >= frame_width) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= frame_height)
                row_pos = 0;
        end
    endfunction

    // Compare an accepted result with the oldest edge due
    function void check_edge(sem_pkg::sem_result_t got);
        sem_pkg::sem_result_t want;
        if (edges_due.size() == 0) begin
            $error("unexpected result: col %0d row %0d", got.out_col, got.out_row);
            errors++;
            return;
        end
        want = edges_due.pop_front();
        if (got.out_col !== want.out_col) begin
            $error("out_col: expected %0d, actual %0d", want.out_col, got.out_col);
            errors++;
        end
        if (got.out_row !== want.out_row) begin
            $error("out_row: expected %0d, actual %0d", want.out_row, got.out_row);
            errors++;
        end
        if (got.magnitude !== want.magnitude) begin
            $error("magnitude: expected %0d, actual %0d", want.magnitude, got.magnitude);
            errors++;
        end
        if (got.out_alpha !== want.out_alpha) begin
            $error("out_alpha: expected %0d, actual %0d", want.out_alpha, got.out_alpha);
            errors++;
        end
        if (got.frame_last !== want.frame_last) begin
            $error("frame_last: expected %0d, actual %0d", want.frame_last, got.frame_last);
            errors++;
        end
    endfunction
endclass

module tb;
    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned TOTAL_ITEMS   = 1750;

    logic                             clk;
    logic                             rst_n;
    logic                             push;
    logic                             full;
    sem_pkg::sem_pixel_t              pixel;
    logic                             empty;
    logic                             pop;
    sem_pkg::sem_result_t             result;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [sem_pkg::APB_ADDR_W-1:0]   paddr;
    logic [sem_pkg::APB_DATA_W-1:0]   pwdata;
    logic [sem_pkg::APB_DATA_W-1:0]   prdata;
    logic                             pready;

    edge_scoreboard sb;
    int unsigned    idle_pct;
    int unsigned    stall_left;
    int unsigned    cycle_count;
    bit [7:0]       drift_level;

    sobel_edge_magnitude_3x3_top DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .pixel   (pixel),
        .empty   (empty),
        .pop     (pop),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Monitor: accepted pixels feed the predictor, accepted results get checked
    always @(posedge clk)
    begin
        if (rst_n === 1'b1) begin
            if (push && !full)
                sb.predict_edge(pixel);
            if (pop && !empty)
                sb.check_edge(result);
        end
    end

    // Result side: pop with random stall bursts
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1) begin
            pop <= 1'b0;
        end
        else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            pop <= 1'b0;
        end
        else if ($urandom_range(99, 0) < idle_pct) begin
            stall_left = $urandom_range(5, 0);
            pop <= 1'b0;
        end
        else begin
            pop <= 1'b1;
        end
    end

    // Smooth areas, full noise and hard black/white mixed
    function automatic sem_pkg::sem_pixel_t textured_pixel();
        sem_pkg::sem_pixel_t p;
        int unsigned pick;
        pick = $urandom_range(9, 0);
        p = sem_pkg::sem_pixel_t'($urandom);
        if (pick < 5) begin
            drift_level = drift_level + 8'($urandom_range(6, 0)) - 8'd3;
            p.red   = drift_level ^ 8'($urandom_range(7, 0));
            p.green = drift_level ^ 8'($urandom_range(7, 0));
            p.blue  = drift_level ^ 8'($urandom_range(7, 0));
        end
        else if (pick >= 8) begin
            p.red   = {8{1'($urandom_range(1, 0))}};
            p.green = {8{1'($urandom_range(1, 0))}};
            p.blue  = {8{1'($urandom_range(1, 0))}};
        end
        return p;
    endfunction

    // Directed 3x3 frames: vertical edge, horizontal edge, gentle ramp
    function automatic sem_pkg::sem_pixel_t probe_pixel(int f, int c, int r);
        sem_pkg::sem_pixel_t p;
        bit [7:0] v;
        case (f)
            0: begin
                v = (c == 0) ? 8'hFF : 8'h00;
                p = '{v, v, v, (c == 1 && r == 1) ? 8'h00 : 8'hFF};
            end
            1: begin
                v = (r == 2) ? 8'hFF : 8'h00;
                p = '{v, v, v, (c == 1 && r == 1) ? 8'hFF : 8'h00};
            end
            default: begin
                p = '{8'(c * 40), 8'(r * 25), (c == 2 && r == 0) ? 8'hFF : 8'h01,
                      8'h5A ^ 8'(c + 3 * r)};
            end
        endcase
        return p;
    endfunction

    function automatic void pick_idle(bit calm);
        case ($urandom_range(2, 0))
            0:       idle_pct = 0;
            1:       idle_pct = 10;
            default: idle_pct = 35;
        endcase
        if (calm)
            idle_pct = 0;
    endfunction

    // Offer one pixel, possibly after an idle burst, and wait for acceptance
    task automatic push_pixel(input sem_pkg::sem_pixel_t px);
        if ($urandom_range(99, 0) < idle_pct) begin
            push <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        push  <= 1'b1;
        pixel <= px;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic feed_pixels(input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
            push_pixel(textured_pixel());
        push <= 1'b0;
    endtask

    // APB write: setup beat, then access beat until pready
    task automatic write_reg(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.apply_reg_write(idx, value);
    endtask

    // Wait for all edges due, then let border pixels drain out of the pipe
    task automatic settle();
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic [31:0] w_word, input logic [31:0] h_word,
                             input int unsigned count, input bit calm);
        settle();
        pick_idle(calm);
        if ($urandom_range(1, 0)) begin
            write_reg(sem_pkg::CFG_IDX_WIDTH, w_word);
            write_reg(sem_pkg::CFG_IDX_HEIGHT, h_word);
        end
        else begin
            write_reg(sem_pkg::CFG_IDX_HEIGHT, h_word);
            write_reg(sem_pkg::CFG_IDX_WIDTH, w_word);
        end
        feed_pixels(count);
    endtask

    initial
    begin
        int unsigned sent_items;
        int unsigned w;
        int unsigned h;
        int unsigned n;
        int unsigned pick;
        logic [31:0] w_word;
        logic [31:0] h_word;
        bit          calm;

        sb = new();
        sent_items   = 0;
        calm         = 1'b0;
        idle_pct     = 0;
        drift_level  = 8'h80;
        rst_n   <= 1'b0;
        push    <= 1'b0;
        pixel   <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset size: two full rows plus 24 pixels of the third row
        pick_idle(1'b0);
        feed_pixels(2 * sem_pkg::RESET_WIDTH + 24);
        sent_items += 2 * sem_pkg::RESET_WIDTH + 24;

        // Directed 3x3 frames back to back, wrapping each time
        settle();
        write_reg(sem_pkg::CFG_IDX_WIDTH, 32'd3);
        write_reg(sem_pkg::CFG_IDX_HEIGHT, 32'd3);
        for (int f = 0; f < 3; f++)
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    push_pixel(probe_pixel(f, c, r));
        push <= 1'b0;
        sent_items += 27;

        // Saturation and size extremes; the widest frame only walks the first row
        run_phase(32'd0, 32'd2, 31, 1'b0);
        run_phase(32'hFFFF_FFFF, 32'd4096, 40, 1'b0);
        run_phase(32'd3, 32'h0000_1FFF, 150, 1'b0);
        sent_items += 31 + 40 + 150;

        // Random sizes, mostly small; last part without idling
        while (sent_items < TOTAL_ITEMS) begin
            pick = $urandom_range(9, 0);
            if (pick < 7)
                w = $urandom_range(16, 3);
            else if (pick < 9)
                w = $urandom_range(64, 17);
            else
                w = $urandom_range(300, 65);
            h = $urandom_range(10, 3);
            if ($urandom_range(7, 0) == 0)
                w = $urandom_range(2, 0);
            if ($urandom_range(7, 0) == 0)
                h = $urandom_range(2, 0);
            n = 2 * ((w < 3) ? 3 : w) + $urandom_range(250, 10);
            if (n > TOTAL_ITEMS + 40 - sent_items)
                n = TOTAL_ITEMS + 40 - sent_items;
            w_word = w;
            h_word = h;
            if ($urandom_range(3, 0) == 0) begin
                w_word = ($urandom & 32'hFFFF_F000) | w;
                h_word = ($urandom & 32'hFFFF_E000) | h;
            end
            calm = (sent_items + 100 >= TOTAL_ITEMS);
            run_phase(w_word, h_word, n, calm);
            sent_items += n;
        end

        settle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
